// ===== sv/stcag_pkg.sv =====
// shared constants and register codes for the strided tensor copy address generator
package stcag_pkg;

   localparam int MAX_DIMS_DEFAULT  = 4;
   localparam int DIM_BITS_DEFAULT  = 16;
   localparam int ADDR_BITS_DEFAULT = 32;

   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int SHAPE_BITS     = 64;
   localparam int BASE_BITS      = 32;
   localparam int DIMS_CFG_BITS  = 3;

   localparam logic MODE_GATHER = 1'b0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE          = 3'd0,
      CSR_DIMS_IN_USE   = 3'd1,
      CSR_SHAPE_SIZES   = 3'd2,
      CSR_STRIDED_STEPS = 3'd3,
      CSR_BASE_OFFSET   = 3'd4
   } csr_index_type;

endpackage

// ===== sv/stcag_req_if.sv =====
// request channel: one advance request per transfer
interface stcag_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

// ===== sv/stcag_rsp_if.sv =====
// response channel: one source and destination address pair per transfer
interface stcag_rsp_if #(
   parameter int ADDR_BITS = stcag_pkg::ADDR_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] src_address;
   logic [ADDR_BITS-1:0] dst_address;
   logic                 last_element;
   logic                 no_transfer;

   modport source (output valid, output src_address, output dst_address,
                   output last_element, output no_transfer, input ready);
   modport sink (input valid, input src_address, input dst_address,
                 input last_element, input no_transfer, output ready);
endinterface

// ===== sv/strided_tensor_copy_address_gen.sv =====
// strided tensor copy address generator top level
//
// Each transfer on req_ch asks for the next element of an odometer walk over
// an N-dimensional tensor; each yields one transfer on rsp_ch carrying the
// source and destination element addresses, a last-element mark and a
// no-transfer flag for zero-sized shapes. restart=1 begins the walk again.
// The strided address and the compact address are kept as running registers
// updated by one add each, so a request is taken every cycle when neither
// setup nor a full output buffer stalls it, and its result is registered.
// The csr port writes mode, dimension count, shape, strides and base offset;
// any write to a known register ends the current walk.
// After reset and after each register write a setup sequencer forms the
// element count and per-dimension address deltas, a multiply and an
// accumulate step per dimension; req_ch.ready stays low meanwhile.
// Results go through a two-entry output buffer: a request is still taken
// while one result waits, and outside setup req_ch.ready drops only when both
// entries are held by a stalled receiver.
module strided_tensor_copy_address_gen #(
   parameter int MAX_DIMS  = stcag_pkg::MAX_DIMS_DEFAULT,
   parameter int DIM_BITS  = stcag_pkg::DIM_BITS_DEFAULT,
   parameter int ADDR_BITS = stcag_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   stcag_req_if.sink                            req_ch,
   stcag_rsp_if.source                          rsp_ch,
   input  logic                                 csr_write_enable,
   input  logic [stcag_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [stcag_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int DCNT_W   = $clog2(MAX_DIMS + 1);
   localparam int DIDX_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int PAD_W    = MAX_DIMS * DIM_BITS + stcag_pkg::SHAPE_BITS;
   localparam int SEQ_LAST = 2 * MAX_DIMS;
   localparam int SEQ_DONE = 2 * MAX_DIMS + 1;
   localparam int SEQ_W    = $clog2(2 * MAX_DIMS + 2);
   localparam int MUL_W    = ADDR_BITS + DIM_BITS;

   typedef struct packed {
      logic [ADDR_BITS-1:0] src_address;
      logic [ADDR_BITS-1:0] dst_address;
      logic                 last_element;
      logic                 no_transfer;
   } rsp_item_type;

   // configuration registers
   logic                                       mode_ff;
   logic [stcag_pkg::DIMS_CFG_BITS-1:0]        dims_ff;
   logic [stcag_pkg::SHAPE_BITS-1:0]           shape_ff;
   logic [stcag_pkg::SHAPE_BITS-1:0]           strides_ff;
   logic [stcag_pkg::BASE_BITS-1:0]            base_ff;
   logic                                       csr_hit;

   // decoded configuration
   logic [PAD_W-1:0]    shape_pad;
   logic [PAD_W-1:0]    strides_pad;
   logic [DIM_BITS-1:0] size_w   [MAX_DIMS];
   logic [DIM_BITS-1:0] top_w    [MAX_DIMS];
   logic [DIM_BITS-1:0] stride_w [MAX_DIMS];
   logic [DCNT_W-1:0]   ud;
   logic                zero_any;

   // setup sequencer
   logic [SEQ_W-1:0]     seq_ff;
   logic [DIDX_W-1:0]    seq_j;
   logic                 seq_used;
   logic                 busy;
   logic [MUL_W-1:0]     cnt_mul;
   logic [MUL_W-1:0]     top_mul;
   logic [ADDR_BITS-1:0] prod_cnt_ff;
   logic [ADDR_BITS-1:0] prod_top_ff;
   logic [ADDR_BITS-1:0] count_ff;
   logic [ADDR_BITS-1:0] suffix_ff;
   logic [ADDR_BITS-1:0] delta_ff [MAX_DIMS];
   logic [ADDR_BITS-1:0] start_ff;
   logic [ADDR_BITS-1:0] count_m1_ff;

   // walk state
   logic                 walk_active_ff;
   logic                 walk_active_in;
   logic [DIM_BITS-1:0]  idx_ff  [MAX_DIMS];
   logic [DIM_BITS-1:0]  idx_in  [MAX_DIMS];
   logic [DIM_BITS-1:0]  cur_idx [MAX_DIMS];
   logic [ADDR_BITS-1:0] str_ff;
   logic [ADDR_BITS-1:0] str_in;
   logic [ADDR_BITS-1:0] cmp_ff;
   logic [ADDR_BITS-1:0] cmp_in;
   logic [ADDR_BITS-1:0] cur_str;
   logic [ADDR_BITS-1:0] cur_cmp;
   logic                 start;
   logic                 last;
   logic [DIDX_W-1:0]    bj;
   logic                 fire;
   rsp_item_type         new_item;

   // output buffer
   rsp_item_type head_ff;
   rsp_item_type head_in;
   rsp_item_type tail_ff;
   rsp_item_type tail_in;
   logic         head_v_ff;
   logic         head_v_in;
   logic         tail_v_ff;
   logic         tail_v_in;
   logic         pop;

   assign csr_hit = csr_write_enable &&
                    (csr_index inside {[stcag_pkg::CSR_MODE:stcag_pkg::CSR_BASE_OFFSET]});

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= stcag_pkg::MODE_GATHER;
         dims_ff    <= stcag_pkg::DIMS_CFG_BITS'(1);
         shape_ff   <= '0;
         strides_ff <= '0;
         base_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            stcag_pkg::CSR_MODE:          mode_ff    <= csr_write_data[0];
            stcag_pkg::CSR_DIMS_IN_USE:
               dims_ff <= csr_write_data[stcag_pkg::DIMS_CFG_BITS-1:0];
            stcag_pkg::CSR_SHAPE_SIZES:   shape_ff   <= csr_write_data;
            stcag_pkg::CSR_STRIDED_STEPS: strides_ff <= csr_write_data;
            stcag_pkg::CSR_BASE_OFFSET:
               base_ff <= csr_write_data[stcag_pkg::BASE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // field extraction, fields past bit 63 read as zero
   always_comb begin
      shape_pad   = {{(PAD_W - stcag_pkg::SHAPE_BITS){1'b0}}, shape_ff};
      strides_pad = {{(PAD_W - stcag_pkg::SHAPE_BITS){1'b0}}, strides_ff};
      for (int i = 0; i < MAX_DIMS; i++) begin
         size_w[i]   = shape_pad[(MAX_DIMS - 1 - i) * DIM_BITS +: DIM_BITS];
         stride_w[i] = strides_pad[(MAX_DIMS - 1 - i) * DIM_BITS +: DIM_BITS];
         top_w[i]    = size_w[i] - DIM_BITS'(1);
      end
   end

   always_comb begin
      if (dims_ff == '0) begin
         ud = DCNT_W'(1);
      end else if (int'(dims_ff) > MAX_DIMS) begin
         ud = DCNT_W'(MAX_DIMS);
      end else begin
         ud = DCNT_W'(dims_ff);
      end
   end

   always_comb begin
      zero_any = 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (i < ud && size_w[i] == '0) begin
            zero_any = 1'b1;
         end
      end
   end

   // setup: a multiply step and an accumulate step per dimension, innermost first, then the start address
   assign busy     = (seq_ff != SEQ_W'(SEQ_DONE));
   assign seq_j    = DIDX_W'(MAX_DIMS - 1) - seq_ff[DIDX_W:1];
   assign seq_used = (seq_j < ud);
   assign cnt_mul  = MUL_W'(count_ff) * MUL_W'(size_w[seq_j]);
   assign top_mul  = MUL_W'(top_w[seq_j]) * MUL_W'(stride_w[seq_j]);

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         seq_ff    <= '0;
         count_ff  <= ADDR_BITS'(1);
         suffix_ff <= '0;
      end else if (busy) begin
         seq_ff <= seq_ff + SEQ_W'(1);
         if (seq_ff == SEQ_W'(SEQ_LAST)) begin
            start_ff    <= ADDR_BITS'(base_ff) + suffix_ff;
            count_m1_ff <= count_ff - ADDR_BITS'(1);
         end else if (!seq_ff[0]) begin
            prod_cnt_ff <= cnt_mul[ADDR_BITS-1:0];
            prod_top_ff <= top_mul[ADDR_BITS-1:0];
         end else if (seq_used) begin
            count_ff        <= prod_cnt_ff;
            suffix_ff       <= suffix_ff + prod_top_ff;
            delta_ff[seq_j] <= suffix_ff - ADDR_BITS'(stride_w[seq_j]);
         end
      end
   end

   // walk step
   assign fire  = req_ch.valid && req_ch.ready;
   assign start = req_ch.restart || !walk_active_ff;

   always_comb begin
      for (int i = 0; i < MAX_DIMS; i++) begin
         cur_idx[i] = start ? top_w[i] : idx_ff[i];
      end
      cur_str = start ? start_ff : str_ff;
      cur_cmp = start ? count_m1_ff : cmp_ff;

      last = 1'b1;
      bj   = '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (i < ud && cur_idx[i] != '0) begin
            last = 1'b0;
            bj   = DIDX_W'(i);
         end
      end

      for (int i = 0; i < MAX_DIMS; i++) begin
         if (i == bj) begin
            idx_in[i] = cur_idx[i] - DIM_BITS'(1);
         end else if (i > bj && i < ud) begin
            idx_in[i] = top_w[i];
         end else begin
            idx_in[i] = cur_idx[i];
         end
      end
      str_in = cur_str + delta_ff[bj];
      cmp_in = cur_cmp - ADDR_BITS'(1);

      walk_active_in = walk_active_ff;
      if (csr_hit) begin
         walk_active_in = 1'b0;
      end else if (fire) begin
         walk_active_in = !(zero_any || last);
      end

      if (zero_any) begin
         new_item = '{src_address: '0, dst_address: '0,
                      last_element: 1'b1, no_transfer: 1'b1};
      end else if (mode_ff == stcag_pkg::MODE_GATHER) begin
         new_item = '{src_address: cur_str, dst_address: cur_cmp,
                      last_element: last, no_transfer: 1'b0};
      end else begin
         new_item = '{src_address: cur_cmp, dst_address: cur_str,
                      last_element: last, no_transfer: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_active_ff <= 1'b0;
      end else begin
         walk_active_ff <= walk_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && !zero_any && !last) begin
         idx_ff <= idx_in;
         str_ff <= str_in;
         cmp_ff <= cmp_in;
      end
   end

   // two-entry output buffer
   assign pop = head_v_ff && rsp_ch.ready;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      head_v_in = head_v_ff;
      tail_v_in = tail_v_ff;
      if (pop) begin
         head_in   = tail_ff;
         head_v_in = tail_v_ff;
         tail_v_in = 1'b0;
      end
      if (fire) begin
         if (!head_v_in) begin
            head_in   = new_item;
            head_v_in = 1'b1;
         end else begin
            tail_in   = new_item;
            tail_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         tail_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         tail_v_ff <= tail_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign req_ch.ready        = !busy && !(head_v_ff && tail_v_ff);
   assign rsp_ch.valid        = head_v_ff;
   assign rsp_ch.src_address  = head_ff.src_address;
   assign rsp_ch.dst_address  = head_ff.dst_address;
   assign rsp_ch.last_element = head_ff.last_element;
   assign rsp_ch.no_transfer  = head_ff.no_transfer;

endmodule
